// ===== sv/assert_macros.svh =====
// Concurrent assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SFCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SFCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfce_pkg.sv =====
// Types, constants and helper functions of the serial frame check encoder.
package sfce_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ASCII_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_CHECK = 2'd1;

    // Check and character constants
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  CHAR_COLON = 8'h3A;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_A_M10 = 8'h37;  // 'A' minus ten

    // One classified payload byte, as queued between front and back
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        ascii;
        logic        check;
        logic        first;
        logic [15:0] crc;
        logic [7:0]  lrc;
    } entry_t;

    // Back-end sequencer: which character goes out next
    typedef enum logic [3:0] {
        S_START,
        S_COLON,
        S_HEX_HI,
        S_HEX_LO,
        S_LRC_HI,
        S_LRC_LO,
        S_CR,
        S_LF,
        S_RAW,
        S_CRC_LO,
        S_CRC_HI
    } seq_state_t;

    // Upper-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (CHAR_ZERO + wide) : (CHAR_A_M10 + wide);
    endfunction

    // Reflected CRC-16 update over one byte, one bit per step
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/sfce_if.sv =====
// Channel interfaces: payload input, framed output and configuration writes.
interface sfce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

interface sfce_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfce_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sfce_front.sv =====
// Front end: takes payload beats, keeps CRC and sum, classifies each byte.
module sfce_front (
    input  logic             clk,
    input  logic             rst_n,
    sfce_in_if.sink          din,
    sfce_cfg_if.sink         cfg,
    output logic             push,
    output sfce_pkg::entry_t push_entry,
    input  logic             q_full
);
    import sfce_pkg::*;

    logic        ascii_reg;
    logic        check_reg;
    logic        mid_reg;
    logic        mid_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] crc_upd;
    logic [7:0]  sum_upd;

    // Handshakes
    assign din.ready = !q_full;
    assign cfg.ready = 1'b1;
    assign push      = din.valid && din.ready;

    // Running checks including this byte
    always_comb
    begin
        crc_upd = crc_update(crc_reg, din.data_byte);
        sum_upd = sum_reg + din.data_byte;
    end

    // Classified entry for the back end
    always_comb
    begin
        push_entry.data  = din.data_byte;
        push_entry.last  = din.last_byte;
        push_entry.ascii = ascii_reg;
        push_entry.check = check_reg;
        push_entry.first = !mid_reg;
        push_entry.crc   = crc_upd;
        push_entry.lrc   = 8'((~sum_upd) + 8'd1);
    end

    // Frame state: reload at the frame's last byte
    always_comb
    begin
        crc_next = crc_reg;
        sum_next = sum_reg;
        mid_next = mid_reg;
        if (push) begin
            if (din.last_byte) begin
                crc_next = CRC_INIT;
                sum_next = 8'h00;
                mid_next = 1'b0;
            end else begin
                crc_next = crc_upd;
                sum_next = sum_upd;
                mid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg <= CRC_INIT;
            sum_reg <= 8'h00;
            mid_reg <= 1'b0;
        end else begin
            crc_reg <= crc_next;
            sum_reg <= sum_next;
            mid_reg <= mid_next;
        end
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ascii_reg <= 1'b0;
            check_reg <= 1'b1;
        end else if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
                CFG_ASCII_MODE:   ascii_reg <= cfg.data[0];
                CFG_INSERT_CHECK: check_reg <= cfg.data[0];
                default:          ;
            endcase
        end
    end

endmodule

// ===== sv/sfce_queue.sv =====
// Short queue of classified entries between front and back end.
module sfce_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfce_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output sfce_pkg::entry_t head,
    output logic             empty
);
    import sfce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/sfce_back.sv =====
// Back end: walks each queued entry through its output characters.
module sfce_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sfce_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    sfce_out_if.source       dout
);
    import sfce_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    seq_state_t cur;
    logic       step_final;
    logic       load_en;
    logic       fire;
    logic [7:0] char_next;
    logic       end_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;

    // Output register frees up when empty or taken this cycle
    assign load_en = !out_valid_reg || dout.ready;
    assign fire    = load_en && !empty;
    assign pop     = fire && step_final;

    // Next state: current character and the one after it
    always_comb
    begin
        if (state_reg == S_START) begin
            if (head.ascii) begin
                cur = head.first ? S_COLON : S_HEX_HI;
            end else begin
                cur = S_RAW;
            end
        end else begin
            cur = state_reg;
        end

        unique case (cur)
            S_COLON:  state_next = S_HEX_HI;
            S_HEX_HI: state_next = S_HEX_LO;
            S_HEX_LO:
            begin
                if (!head.last) begin
                    state_next = S_START;
                end else begin
                    state_next = head.check ? S_LRC_HI : S_CR;
                end
            end
            S_LRC_HI: state_next = S_LRC_LO;
            S_LRC_LO: state_next = S_CR;
            S_CR:     state_next = S_LF;
            S_RAW:    state_next = (head.last && head.check) ? S_CRC_LO : S_START;
            S_CRC_LO: state_next = S_CRC_HI;
            default:  state_next = S_START;
        endcase
        step_final = (state_next == S_START);
    end

    // Outputs: character for the current step
    always_comb
    begin
        unique case (cur)
            S_COLON:  char_next = CHAR_COLON;
            S_HEX_HI: char_next = hex_char(head.data[7:4]);
            S_HEX_LO: char_next = hex_char(head.data[3:0]);
            S_LRC_HI: char_next = hex_char(head.lrc[7:4]);
            S_LRC_LO: char_next = hex_char(head.lrc[3:0]);
            S_CR:     char_next = CHAR_CR;
            S_LF:     char_next = CHAR_LF;
            S_CRC_LO: char_next = head.crc[7:0];
            S_CRC_HI: char_next = head.crc[15:8];
            default:  char_next = head.data;
        endcase
        end_next = step_final && head.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_START;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
            end
            if (load_en) begin
                out_valid_reg <= !empty;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire) begin
            out_byte_reg  <= char_next;
            frame_end_reg <= end_next;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.out_byte  = out_byte_reg;
    assign dout.frame_end = frame_end_reg;

endmodule

// ===== sv/serial_frame_check_encoder.sv =====
// Top level of the serial frame check encoder (RTU CRC-16 / ASCII LRC framing).
//
// Channels: din takes payload beats (data_byte, last_byte marks the frame's
// last byte); dout gives framed beats (out_byte, frame_end on the frame's last
// character); cfg writes ascii_mode (index 0) and insert_check (index 1),
// bit 0 of data; other indexes are ignored. cfg is always ready; write it
// only while no frame is in flight.
// Flow: the first character of a byte goes from din via the queue and the
// output register to dout. The back end sends one character per cycle while
// dout is ready; a byte gives 1 character (RTU, 3 with the CRC at frame end),
// 2 (ASCII), 3 (ASCII frame start), up to 7 (one-byte ASCII frame with check);
// the front takes one beat per cycle while the QUEUE_DEPTH-entry queue has room.
// Reset: CRC reloads to 0xFFFF, the sum clears, the next byte starts a frame,
// ascii_mode = 0, insert_check = 1; the queue and output register empty.
// A stall on dout holds the output beat; the queue then fills and din ready
// drops until the back end moves again.
module serial_frame_check_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    sfce_in_if.sink    din,
    sfce_out_if.source dout,
    sfce_cfg_if.sink   cfg
);
    import sfce_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    entry_t push_entry;
    entry_t head;

    sfce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .cfg        (cfg),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    sfce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    sfce_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (q_empty),
        .pop   (pop),
        .dout  (dout)
    );

endmodule

// ===== sv/sfce_checker.sv =====
// Port-level checker for the serial frame check encoder, with its bind.
`include "assert_macros.svh"

module sfce_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       frame_end
);
    logic       seen_reg;
    logic [7:0] open_reg;
    logic [7:0] open_next;
    logic       in_beat;
    logic       end_beat;
    logic       out_stall;
    logic [8:0] out_beat;

    assign in_beat   = in_valid && in_ready;
    assign end_beat  = out_valid && out_ready && frame_end;
    assign out_stall = out_valid && !out_ready;
    assign out_beat  = {frame_end, out_byte};

    // Frames whose last payload byte went in but whose end has not come out
    always_comb
    begin
        open_next = open_reg;
        case ({in_beat && in_last, end_beat})
            2'b10:   open_next = open_reg + 8'd1;
            2'b01:   open_next = open_reg - 8'd1;
            default: open_next = open_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            open_reg <= 8'd0;
        end
        else
        begin
            seen_reg <= seen_reg || in_beat;
            open_reg <= open_next;
        end
    end

    `SFCE_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_beat), "beat moved")
    `SFCE_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, seen_reg, "beat before any input")
    `SFCE_ASSERT_IMP(a_end_has_frame, clk, rst_n, end_beat, open_reg != 8'd0, "stray frame end")

endmodule

bind serial_frame_check_encoder sfce_port_checker u_sfce_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_last   (din.last_byte),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_byte  (dout.out_byte),
    .frame_end (dout.frame_end)
);

// ===== dv/sfce_checker.sv =====
// Checker of the serial frame check encoder: predicts framed characters and compares them.
`timescale 1ns / 1ps

module sfce_checker
    import sfce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sfce_in_if   din,
    sfce_out_if  dout,
    sfce_cfg_if  cfg,
    input  logic end_of_run,
    output int   fail_count,
    output int   chars_pending
);

    localparam logic [7:0] CH_A      = 8'h41;
    localparam int         PRINT_CAP = 40;

    // One framed character as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } tx_char_t;

    tx_char_t    tx_chars_due[$];

    // Predictor copy of the registers and the running checks
    logic        ascii_sel;
    logic        check_sel;
    logic [15:0] crc_run;
    logic [7:0]  lrc_sum;
    logic        frame_open;
    logic        leftovers_done;

    // Reflected CRC-16, one payload bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        return (nib < 4'd10) ? (CHAR_ZERO + 8'(nib)) : (CH_A + 8'(nib) - 8'd10);
    endfunction

    function automatic tx_char_t mk_char(input logic [7:0] ch, input logic fin);
        tx_char_t t;
        t.ch  = ch;
        t.fin = fin;
        return t;
    endfunction

    // Work out the characters one payload beat causes
    task automatic encode_payload_byte(input logic [7:0] b, input logic last);
        logic [7:0] lrc;
        crc_run = crc16_step(crc_run, b);
        lrc_sum = lrc_sum + b;
        if (!ascii_sel)
        begin
            tx_chars_due.push_back(mk_char(b, last && !check_sel));
            if (last && check_sel)
            begin
                tx_chars_due.push_back(mk_char(crc_run[7:0], 1'b0));
                tx_chars_due.push_back(mk_char(crc_run[15:8], 1'b1));
            end
        end
        else
        begin
            if (!frame_open)
                tx_chars_due.push_back(mk_char(CHAR_COLON, 1'b0));
            tx_chars_due.push_back(mk_char(ascii_hex(b[7:4]), 1'b0));
            tx_chars_due.push_back(mk_char(ascii_hex(b[3:0]), 1'b0));
            if (last)
            begin
                if (check_sel)
                begin
                    lrc = 8'd0 - lrc_sum;
                    tx_chars_due.push_back(mk_char(ascii_hex(lrc[7:4]), 1'b0));
                    tx_chars_due.push_back(mk_char(ascii_hex(lrc[3:0]), 1'b0));
                end
                tx_chars_due.push_back(mk_char(CHAR_CR, 1'b0));
                tx_chars_due.push_back(mk_char(CHAR_LF, 1'b1));
            end
        end
        // frame boundary: checks restart
        if (last)
        begin
            crc_run    = CRC_INIT;
            lrc_sum    = 8'd0;
            frame_open = 1'b0;
        end
        else
            frame_open = 1'b1;
    endtask

    task automatic flag_mismatch(input string what);
        if (fail_count < PRINT_CAP)
            $display("[chk] %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Watch the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        tx_char_t want;
        if (!rst_n)
        begin
            ascii_sel      = 1'b0;
            check_sel      = 1'b1;
            crc_run        = CRC_INIT;
            lrc_sum        = 8'd0;
            frame_open     = 1'b0;
            leftovers_done = 1'b0;
            fail_count     = 0;
            tx_chars_due.delete();
            chars_pending  = 0;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ASCII_MODE)
                    ascii_sel = cfg.data[0];
                else if (cfg.index == CFG_INSERT_CHECK)
                    check_sel = cfg.data[0];
            end
            // payload beat in
            if (din.valid && din.ready)
                encode_payload_byte(din.data_byte, din.last_byte);
            // framed beat out
            if (dout.valid && dout.ready)
            begin
                if (tx_chars_due.size() == 0)
                    flag_mismatch($sformatf("unexpected beat out_byte=%02h frame_end=%0b",
                                            dout.out_byte, dout.frame_end));
                else
                begin
                    want = tx_chars_due.pop_front();
                    if (dout.out_byte !== want.ch)
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                dout.out_byte, want.ch));
                    if (dout.frame_end !== want.fin)
                        flag_mismatch($sformatf("frame_end %0b, expected %0b on char %02h",
                                                dout.frame_end, want.fin, want.ch));
                end
            end
            // anything still owed at the end is lost
            if (end_of_run && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (tx_chars_due.size() != 0)
                    flag_mismatch($sformatf("%0d framed characters never arrived",
                                            tx_chars_due.size()));
            end
            chars_pending = tx_chars_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the serial frame check encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import sfce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_3  = 2'd3;
    localparam int                   STALL_LIMIT = 3000;
    localparam int                   SEG_ITEMS   = 26;

    logic clk;
    logic rst_n;
    logic end_of_run;
    int   fail_count;
    int   chars_pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   stall_cycles;

    sfce_in_if  din_ch ();
    sfce_out_if dout_ch ();
    sfce_cfg_if cfg_ch ();

    serial_frame_check_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    sfce_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (din_ch),
        .dout          (dout_ch),
        .cfg           (cfg_ch),
        .end_of_run    (end_of_run),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        dout_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles = 0;
        else if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One payload beat; valid stays up for a following beat
    task automatic push_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            din_ch.valid <= 1'b0;
            @(negedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.data_byte <= b;
        din_ch.last_byte <= last;
        do @(posedge clk); while (!din_ch.ready);
        @(negedge clk);
    endtask

    // Stop sending and let every owed character drain
    task automatic wait_idle();
        din_ch.valid <= 1'b0;
        do @(negedge clk); while (chars_pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        int         sent;
        int         len;
        logic       cut;
        logic [1:0] mode_pick;
        logic [7:0] hex_run[8];

        rst_n             = 1'b0;
        end_of_run        = 1'b0;
        din_ch.valid      = 1'b0;
        din_ch.data_byte  = 8'h00;
        din_ch.last_byte  = 1'b0;
        dout_ch.ready     = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_ASCII_MODE;
        cfg_ch.data       = 8'h00;
        send_idle_pct     = 11;
        recv_idle_pct     = 66;
        hex_run           = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset defaults are RTU with CRC
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b1);
        push_beat(8'hA5, 1'b1);
        // unused indexes must not touch the registers
        wait_idle();
        write_reg(CFG_NONE_2, 8'hFF);
        write_reg(CFG_NONE_3, 8'hFE);
        push_beat(8'h7E, 1'b1);
        // ASCII with LRC: one-byte frame, then every hex digit
        wait_idle();
        write_reg(CFG_ASCII_MODE, 8'h01);
        push_beat(8'hFF, 1'b1);
        foreach (hex_run[i])
            push_beat(hex_run[i], i == 7);
        // ASCII without check: CR LF right after the hex
        wait_idle();
        write_reg(CFG_INSERT_CHECK, 8'h00);
        push_beat(8'h3C, 1'b1);
        // RTU without check: last payload byte ends the frame
        wait_idle();
        write_reg(CFG_ASCII_MODE, 8'h00);
        push_beat(8'h80, 1'b0);
        push_beat(8'h7F, 1'b1);
        // mode switched in the middle of a frame, both ways
        wait_idle();
        write_reg(CFG_INSERT_CHECK, 8'h01);
        push_beat(8'h12, 1'b0);
        wait_idle();
        write_reg(CFG_ASCII_MODE, 8'h01);
        push_beat(8'h34, 1'b1);
        push_beat(8'h56, 1'b0);
        wait_idle();
        write_reg(CFG_ASCII_MODE, 8'h00);
        push_beat(8'h78, 1'b1);

        // Random frames in three idling phases, settings changed between segments
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 11 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                mode_pick = 2'(seg + phase);
                wait_idle();
                write_reg(CFG_ASCII_MODE, {7'($urandom_range(127)), mode_pick[1]});
                write_reg(CFG_INSERT_CHECK, {7'($urandom_range(127)), mode_pick[0]});
                if ($urandom_range(3) == 0)
                    write_reg($urandom_range(1) ? CFG_NONE_2 : CFG_NONE_3,
                              8'($urandom_range(255)));
                sent = 0;
                while (sent < SEG_ITEMS)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
                    // sometimes leave the frame open across the settings change
                    cut = (sent + len >= SEG_ITEMS) && ($urandom_range(2) == 0);
                    for (int i = 0; i < len; i++)
                        push_beat(pick_byte(), (i == len - 1) && !cut);
                    sent += len;
                end
            end
        end
        push_beat(pick_byte(), 1'b1);

        // Drain, settle, then judge
        wait_idle();
        repeat (10) @(negedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
